// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the mov/add decoder.
// Depends on nothing; simulation builds get the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hw/rtl/mad_pkg.sv =====
// Package for the mov/add instruction decoder: form codes, result layout
// and the opcode and length decode functions. Depends on nothing.
package mad_pkg;

  // Instruction form codes reported in the result.
  localparam logic [3:0] FORM_UNKNOWN    = 4'd0;
  localparam logic [3:0] FORM_MOV_RM_REG = 4'd1;
  localparam logic [3:0] FORM_MOV_IMM_RM = 4'd2;
  localparam logic [3:0] FORM_MOV_IMM_RG = 4'd3;
  localparam logic [3:0] FORM_MOV_MEM_AC = 4'd4;
  localparam logic [3:0] FORM_MOV_AC_MEM = 4'd5;
  localparam logic [3:0] FORM_ADD_RM_REG = 4'd6;
  localparam logic [3:0] FORM_ADD_IMM_RM = 4'd7;
  localparam logic [3:0] FORM_ADD_IMM_AC = 4'd8;

  // Widths of the output stream.
  localparam int OUT_DATA_W = 56;
  localparam int RESULT_W   = 51;

  // Decoded result, declared from the highest tdata bit down to bit 0.
  typedef struct packed {
    logic [2:0]  length;
    logic [15:0] imm_word;
    logic [15:0] disp_word;
    logic        direct_address;
    logic [2:0]  rm_field;
    logic [2:0]  reg_field;
    logic [1:0]  mode_field;
    logic        sign_bit;
    logic        wide_bit;
    logic        dir_bit;
    logic [3:0]  form;
  } result_t;

  // Maps an opcode byte to its instruction form.
  function automatic logic [3:0] form_of(input logic [7:0] op);
    logic [3:0] f;
    f = FORM_UNKNOWN;
    priority if (op[7:4] == 4'hB)         f = FORM_MOV_IMM_RG;
    else if (op[7:2] == 6'b100010)        f = FORM_MOV_RM_REG;
    else if (op[7:2] == 6'b000000)        f = FORM_ADD_RM_REG;
    else if (op[7:2] == 6'b100000)        f = FORM_ADD_IMM_RM;
    else if (op[7:1] == 7'b1100011)       f = FORM_MOV_IMM_RM;
    else if (op[7:1] == 7'b1010000)       f = FORM_MOV_MEM_AC;
    else if (op[7:1] == 7'b1010001)       f = FORM_MOV_AC_MEM;
    else if (op[7:1] == 7'b0000010)       f = FORM_ADD_IMM_AC;
    else                                  f = FORM_UNKNOWN;
    return f;
  endfunction

  // True for forms that carry a ModRM byte.
  function automatic logic has_modrm(input logic [3:0] f);
    return (f == FORM_MOV_RM_REG) || (f == FORM_MOV_IMM_RM) ||
           (f == FORM_ADD_RM_REG) || (f == FORM_ADD_IMM_RM);
  endfunction

  // Operand width bit; the register-immediate move keeps it in bit 3.
  function automatic logic wide_of(input logic [3:0] f, input logic [7:0] op);
    return (f == FORM_MOV_IMM_RG) ? op[3] : op[0];
  endfunction

  // Number of displacement or address bytes.
  function automatic logic [1:0] disp_len(input logic [3:0] f, input logic [7:0] modrm);
    logic [1:0] n;
    n = 2'd0;
    if ((f == FORM_MOV_MEM_AC) || (f == FORM_MOV_AC_MEM)) begin
      n = 2'd2;
    end else if (has_modrm(f)) begin
      if (modrm[7:6] == 2'd1) begin
        n = 2'd1;
      end else if (modrm[7:6] == 2'd2) begin
        n = 2'd2;
      end else if ((modrm[7:6] == 2'd0) && (modrm[2:0] == 3'd6)) begin
        n = 2'd2;
      end
    end
    return n;
  endfunction

  // Number of immediate bytes.
  function automatic logic [1:0] imm_len(input logic [3:0] f, input logic [7:0] op);
    logic [1:0] n;
    n = 2'd0;
    if ((f == FORM_MOV_IMM_RM) || (f == FORM_MOV_IMM_RG) || (f == FORM_ADD_IMM_AC)) begin
      n = wide_of(f, op) ? 2'd2 : 2'd1;
    end else if (f == FORM_ADD_IMM_RM) begin
      n = (op[0] && !op[1]) ? 2'd2 : 2'd1;
    end
    return n;
  endfunction

  // Total instruction length in bytes.
  function automatic logic [2:0] total_len(input logic [3:0] f, input logic [7:0] op,
                                           input logic [7:0] modrm);
    return 3'd1 + {2'b00, has_modrm(f)} + {1'b0, disp_len(f, modrm)} +
           {1'b0, imm_len(f, op)};
  endfunction

endpackage

// ===== hw/rtl/mov_add_instruction_decoder_top.sv =====
// Top level of the mov/add instruction decoder: byte-serial decode with a
// registered result stage. Depends on mad_pkg and assert_macros.svh.
//
// Usage:
//   The input stream carries one code byte per transaction in in_tdata; in_tlast
//   marks the final byte of the program. Every accepted byte updates the
//   partial-instruction registers (position, opcode, ModRM, displacement,
//   immediate). The byte that completes an instruction, an unknown opcode byte,
//   or a last byte in the middle of an instruction produces one result
//   transaction on the output stream; out_tuser flags a truncated instruction.
//   Latency: a result appears in the cycle after the byte that completes it.
//   Throughput: one byte per cycle while in_tready is high; the position and field
//   update is made for each accepted byte.
//   The output register frees the input side: a new byte is taken while a
//   result waits, as long as that result is taken in the same cycle or the
//   register is empty. When the receiver stalls with a result held, in_tready
//   drops until out_tready returns.
//   A synchronous reset (rst_n low) discards any partial instruction and any
//   pending result; the decoder then waits for an opcode byte.
module mov_add_instruction_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [7:0] code_byte
  input  logic                              in_tlast,  // last_byte
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [3:0] form, [4] dir_bit, [5] wide_bit, [6] sign_bit, [8:7] mode_field,
  // [11:9] reg_field, [14:12] rm_field, [15] direct_address, [31:16] disp_word,
  // [47:32] imm_word, [50:48] length, [55:51] zero
  output logic [mad_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser  // truncated
);
  import mad_pkg::*;
  `include "assert_macros.svh"

  // Partial-instruction state.
  logic [2:0]  pos_r, pos_nxt;
  logic [2:0]  needed_r, needed_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  modrm_r, modrm_nxt;
  logic [15:0] disp_r, disp_nxt;
  logic [15:0] imm_r, imm_nxt;

  // Output stage.
  logic        out_valid_r;
  result_t     out_res_r;
  logic        out_trunc_r;

  // Decode results of the current byte.
  logic        in_fire;
  logic        emit;
  logic        trunc;
  logic [3:0]  cur_form;
  logic [2:0]  step_pos;
  result_t     res;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Next state of the partial instruction for the byte on the input.
  always_comb begin
    logic [2:0] ds;
    logic [2:0] de;
    logic [2:0] rel;
    pos_nxt    = pos_r;
    needed_nxt = needed_r;
    opcode_nxt = opcode_r;
    modrm_nxt  = modrm_r;
    disp_nxt   = disp_r;
    imm_nxt    = imm_r;
    emit       = 1'b0;
    trunc      = 1'b0;
    step_pos   = 3'd1;
    ds         = 3'd1;
    de         = 3'd1;
    rel        = 3'd0;
    if (pos_r == 3'd0) begin
      cur_form = form_of(in_tdata);
      if (cur_form != FORM_UNKNOWN) begin
        opcode_nxt = in_tdata;
        modrm_nxt  = 8'h00;
        disp_nxt   = 16'h0000;
        imm_nxt    = 16'h0000;
        needed_nxt = has_modrm(cur_form) ? 3'd2 : total_len(cur_form, in_tdata, 8'h00);
      end
    end else begin
      cur_form = form_of(opcode_r);
      if (has_modrm(cur_form) && (pos_r == 3'd1)) begin
        modrm_nxt  = in_tdata;
        needed_nxt = total_len(cur_form, opcode_r, in_tdata);
      end else begin
        // Place the byte in the displacement or the immediate, low byte first.
        ds = has_modrm(cur_form) ? 3'd2 : 3'd1;
        de = ds + {1'b0, disp_len(cur_form, modrm_r)};
        if ((pos_r >= ds) && (pos_r < de)) begin
          rel = pos_r - ds;
          if (rel == 3'd0) disp_nxt[7:0] = in_tdata;
          else             disp_nxt[15:8] = in_tdata;
        end else if (pos_r >= de) begin
          rel = pos_r - de;
          if (rel == 3'd0) imm_nxt[7:0] = in_tdata;
          else             imm_nxt[15:8] = in_tdata;
        end
      end
      step_pos = pos_r + 3'd1;
    end

    // Decide whether this byte ends the instruction.
    if (cur_form == FORM_UNKNOWN) begin
      emit     = 1'b1;
      step_pos = 3'd1;
      pos_nxt  = 3'd0;
    end else if (step_pos >= needed_nxt) begin
      emit    = 1'b1;
      pos_nxt = 3'd0;
    end else if (in_tlast) begin
      emit    = 1'b1;
      trunc   = 1'b1;
      pos_nxt = 3'd0;
    end else begin
      pos_nxt = step_pos;
    end
  end

  // Result fields from the updated instruction registers.
  always_comb begin
    logic [1:0] dl;
    logic [1:0] il;
    logic       mr;
    res = '0;
    dl  = disp_len(cur_form, modrm_nxt);
    il  = imm_len(cur_form, opcode_nxt);
    mr  = has_modrm(cur_form);
    res.form   = cur_form;
    res.length = step_pos;
    if (cur_form != FORM_UNKNOWN) begin
      res.dir_bit  = ((cur_form == FORM_MOV_RM_REG) || (cur_form == FORM_ADD_RM_REG)) ?
                     opcode_nxt[1] : 1'b0;
      res.wide_bit = wide_of(cur_form, opcode_nxt);
      res.sign_bit = (cur_form == FORM_ADD_IMM_RM) ? opcode_nxt[1] : 1'b0;
      if (mr) begin
        res.mode_field     = modrm_nxt[7:6];
        res.reg_field      = modrm_nxt[5:3];
        res.rm_field       = modrm_nxt[2:0];
        res.direct_address = (modrm_nxt[7:6] == 2'd0) && (modrm_nxt[2:0] == 3'd6);
      end else if (cur_form == FORM_MOV_IMM_RG) begin
        res.reg_field = opcode_nxt[2:0];
      end
      // A byte displacement is sign-extended.
      if (dl == 2'd1)      res.disp_word = {{8{disp_nxt[7]}}, disp_nxt[7:0]};
      else if (dl == 2'd2) res.disp_word = disp_nxt;
      // A byte immediate is zero-extended, or sign-extended for add with s set.
      if (il == 2'd1) begin
        if ((cur_form == FORM_ADD_IMM_RM) && opcode_nxt[1])
          res.imm_word = {{8{imm_nxt[7]}}, imm_nxt[7:0]};
        else
          res.imm_word = {8'h00, imm_nxt[7:0]};
      end else if (il == 2'd2) begin
        res.imm_word = imm_nxt;
      end
    end
  end

  // Instruction state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 3'd0;
      needed_r <= 3'd0;
      opcode_r <= 8'h00;
      modrm_r  <= 8'h00;
      disp_r   <= 16'h0000;
      imm_r    <= 16'h0000;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      needed_r <= needed_nxt;
      opcode_r <= opcode_nxt;
      modrm_r  <= modrm_nxt;
      disp_r   <= disp_nxt;
      imm_r    <= imm_nxt;
    end
  end

  // Output register: loads a new result, or empties when the current one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_res_r   <= res;
      out_trunc_r <= trunc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, out_res_r};
  assign out_tuser  = out_trunc_r;

  // A partial instruction always holds a known opcode and is short of its length.
  `ASSERT_PROP(a_known_opcode, clk, rst_n,
               (pos_r != 3'd0) |-> (form_of(opcode_r) != FORM_UNKNOWN),
               "partial instruction holds an unknown opcode")
  `ASSERT_PROP(a_pos_below_needed, clk, rst_n,
               (pos_r != 3'd0) |-> (pos_r < needed_r),
               "partial instruction position reached its length")
  // Every result reports a length of one to six bytes.
  `ASSERT_NEVER(a_length_range, clk, rst_n,
                out_valid_r && ((out_res_r.length == 3'd0) || (out_res_r.length == 3'd7)),
                "result length out of range")

endmodule

// ===== tb/mov_add_instruction_decoder_top_test.sv =====
// Testbench for the mov/add instruction decoder: directed and random byte streams,
// each result checked against an in-bench decode of the same bytes.
// Depends on mad_pkg and mov_add_instruction_decoder_top.
module mov_add_instruction_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mad_pkg::*;

  // Expected result: the decoded fields plus the truncation flag carried on tuser.
  typedef struct packed {
    logic    truncated;
    result_t res;
  } decode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Partial instruction as the bench sees it.
  logic [2:0]  instr_pos = 3'd0;
  logic [2:0]  instr_need = 3'd0;
  logic [7:0]  instr_opcode = 8'h00;
  logic [7:0]  instr_modrm = 8'h00;
  logic [15:0] instr_disp = 16'h0000;
  logic [15:0] instr_imm = 16'h0000;

  decode_t expected_decodes[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  bit      calm_phase = 1'b0;
  int      rx_stall_left = 0;

  mov_add_instruction_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Opcode byte to instruction form.
  function automatic logic [3:0] opcode_form(input logic [7:0] op);
    casez (op)
      8'b1011????: return FORM_MOV_IMM_RG;
      8'b100010??: return FORM_MOV_RM_REG;
      8'b000000??: return FORM_ADD_RM_REG;
      8'b100000??: return FORM_ADD_IMM_RM;
      8'b1100011?: return FORM_MOV_IMM_RM;
      8'b1010000?: return FORM_MOV_MEM_AC;
      8'b1010001?: return FORM_MOV_AC_MEM;
      8'b0000010?: return FORM_ADD_IMM_AC;
      default:     return FORM_UNKNOWN;
    endcase
  endfunction

  function automatic bit uses_modrm(input logic [3:0] f);
    return f == FORM_MOV_RM_REG || f == FORM_MOV_IMM_RM ||
           f == FORM_ADD_RM_REG || f == FORM_ADD_IMM_RM;
  endfunction

  function automatic logic operand_wide(input logic [3:0] f, input logic [7:0] op);
    return (f == FORM_MOV_IMM_RG) ? op[3] : op[0];
  endfunction

  // Displacement or address bytes that follow the opcode and ModRM.
  function automatic int addr_bytes(input logic [3:0] f, input logic [7:0] modrm);
    if (f == FORM_MOV_MEM_AC || f == FORM_MOV_AC_MEM) return 2;
    if (!uses_modrm(f)) return 0;
    case (modrm[7:6])
      2'd1:    return 1;
      2'd2:    return 2;
      2'd0:    return (modrm[2:0] == 3'd6) ? 2 : 0;
      default: return 0;
    endcase
  endfunction

  // Immediate bytes at the end of the instruction.
  function automatic int data_bytes(input logic [3:0] f, input logic [7:0] op);
    case (f)
      FORM_MOV_IMM_RM, FORM_MOV_IMM_RG, FORM_ADD_IMM_AC:
        return operand_wide(f, op) ? 2 : 1;
      FORM_ADD_IMM_RM:
        return (op[0] && !op[1]) ? 2 : 1;
      default:
        return 0;
    endcase
  endfunction

  // Builds the result for the instruction currently held.
  function automatic decode_t describe_instr(input logic [3:0] f, input logic [2:0] len,
                                             input logic trunc);
    decode_t d;
    d = '0;
    d.res.form = f;
    d.res.length = 3'd1;
    if (f == FORM_UNKNOWN) return d;
    d.res.dir_bit = (f == FORM_MOV_RM_REG || f == FORM_ADD_RM_REG) ? instr_opcode[1] : 1'b0;
    d.res.wide_bit = operand_wide(f, instr_opcode);
    d.res.sign_bit = (f == FORM_ADD_IMM_RM) ? instr_opcode[1] : 1'b0;
    if (uses_modrm(f)) begin
      d.res.mode_field = instr_modrm[7:6];
      d.res.reg_field = instr_modrm[5:3];
      d.res.rm_field = instr_modrm[2:0];
      d.res.direct_address = (instr_modrm[7:6] == 2'd0) && (instr_modrm[2:0] == 3'd6);
    end else if (f == FORM_MOV_IMM_RG) begin
      d.res.reg_field = instr_opcode[2:0];
    end
    // A byte displacement is sign-extended.
    case (addr_bytes(f, instr_modrm))
      1:       d.res.disp_word = {{8{instr_disp[7]}}, instr_disp[7:0]};
      2:       d.res.disp_word = instr_disp;
      default: d.res.disp_word = 16'h0000;
    endcase
    // A byte immediate is sign-extended only for add imm-r/m with s set.
    case (data_bytes(f, instr_opcode))
      1: begin
        if (f == FORM_ADD_IMM_RM && instr_opcode[1]) begin
          d.res.imm_word = {{8{instr_imm[7]}}, instr_imm[7:0]};
        end else begin
          d.res.imm_word = {8'h00, instr_imm[7:0]};
        end
      end
      2:       d.res.imm_word = instr_imm;
      default: d.res.imm_word = 16'h0000;
    endcase
    d.res.length = len;
    d.truncated = trunc;
    return d;
  endfunction

  // Advances the bench's decode by one accepted byte and queues any result it completes.
  task automatic track_byte(input logic [7:0] code, input logic final_byte);
    logic [3:0] f;
    int         p;
    int         ds;
    int         dl;
    if (instr_pos == 3'd0) begin
      f = opcode_form(code);
      if (f == FORM_UNKNOWN) begin
        expected_decodes.push_back(describe_instr(FORM_UNKNOWN, 3'd1, 1'b0));
        return;
      end
      instr_opcode = code;
      instr_modrm = 8'h00;
      instr_disp = 16'h0000;
      instr_imm = 16'h0000;
      instr_pos = 3'd1;
      instr_need = uses_modrm(f) ? 3'd2 : 3'(1 + addr_bytes(f, 8'h00) + data_bytes(f, code));
    end else begin
      p = int'(instr_pos);
      f = opcode_form(instr_opcode);
      if (uses_modrm(f) && p == 1) begin
        instr_modrm = code;
        instr_need = 3'(2 + addr_bytes(f, code) + data_bytes(f, instr_opcode));
      end else begin
        ds = uses_modrm(f) ? 2 : 1;
        dl = addr_bytes(f, instr_modrm);
        // Displacement first, then immediate, each low byte first.
        if (p < ds + dl) begin
          if (p == ds) instr_disp[7:0] = code;
          else instr_disp[15:8] = code;
        end else begin
          if (p == ds + dl) instr_imm[7:0] = code;
          else instr_imm[15:8] = code;
        end
      end
      instr_pos = 3'(p + 1);
    end
    if (instr_pos >= instr_need) begin
      expected_decodes.push_back(describe_instr(f, instr_pos, 1'b0));
      instr_pos = 3'd0;
    end else if (final_byte) begin
      expected_decodes.push_back(describe_instr(f, instr_pos, 1'b1));
      instr_pos = 3'd0;
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compares each result transaction with the oldest expected decode.
  always @(posedge clk) begin : result_check
    decode_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_decodes.size() == 0) begin
        $error("result transaction with no instruction pending: tdata 0x%0h", out_tdata);
        mismatches++;
      end else begin
        want = expected_decodes.pop_front();
        got = out_tdata[RESULT_W-1:0];
        check_field("form", 16'(want.res.form), 16'(got.form));
        check_field("dir_bit", 16'(want.res.dir_bit), 16'(got.dir_bit));
        check_field("wide_bit", 16'(want.res.wide_bit), 16'(got.wide_bit));
        check_field("sign_bit", 16'(want.res.sign_bit), 16'(got.sign_bit));
        check_field("mode_field", 16'(want.res.mode_field), 16'(got.mode_field));
        check_field("reg_field", 16'(want.res.reg_field), 16'(got.reg_field));
        check_field("rm_field", 16'(want.res.rm_field), 16'(got.rm_field));
        check_field("direct_address", 16'(want.res.direct_address),
                    16'(got.direct_address));
        check_field("disp_word", want.res.disp_word, got.disp_word);
        check_field("imm_word", want.res.imm_word, got.imm_word);
        check_field("length", 16'(want.res.length), 16'(got.length));
        check_field("truncated", 16'(want.truncated), 16'(out_tuser));
      end
    end
  end

  // Receiver: random stall bursts, none in the calm phase.
  always @(posedge clk) begin
    if (calm_phase) begin
      out_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Sends one code byte and waits for its transaction; may idle afterwards.
  task automatic send_byte(input logic [7:0] code, input logic final_byte);
    in_tdata <= code;
    in_tlast <= final_byte;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    track_byte(code, final_byte);
    if (!calm_phase && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Sends the first n bytes of an instruction, lowest byte first.
  task automatic send_instr(input int n, input logic [47:0] bytes, input logic final_byte);
    for (int i = 0; i < n; i++) begin
      send_byte(bytes[8*i +: 8], final_byte && (i == n - 1));
    end
  endtask

  // Holds the sender until every expected result has been taken.
  task automatic drain_decodes();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_decodes.size() != 0);
  endtask

  // Every form, operand-size and addressing mode, plus unknown opcodes.
  task automatic test_each_form();
    send_instr(1, 48'hFF, 1'b0);
    send_instr(1, 48'h0F, 1'b1);                  // unknown opcode with last set
    send_instr(2, 48'hD8_89, 1'b0);               // register mode
    send_instr(4, 48'h12_34_06_8B, 1'b0);         // direct address
    send_instr(3, 48'h80_47_88, 1'b0);            // negative byte displacement
    send_instr(4, 48'hFF_FF_87_8A, 1'b0);         // word displacement
    send_instr(5, 48'hAA_01_00_06_C6, 1'b0);
    send_instr(6, 48'h12_34_FE_FF_86_C7, 1'b0);   // longest instruction
    send_instr(3, 48'h55_F8_C6, 1'b0);            // nonzero reg field in mov imm-r/m
    send_instr(2, 48'h7F_B0, 1'b0);
    send_instr(3, 48'hFF_FF_BF, 1'b0);
    send_instr(3, 48'h00_00_A0, 1'b0);
    send_instr(3, 48'hFF_FF_A3, 1'b0);
    send_instr(2, 48'hC0_00, 1'b0);
    send_instr(2, 48'h3F_03, 1'b0);
    send_instr(3, 48'hFF_C1_80, 1'b0);
    send_instr(4, 48'h80_00_C2_81, 1'b0);         // word immediate, s clear
    send_instr(3, 48'h80_C3_83, 1'b0);            // sign-extended byte immediate
    send_instr(3, 48'hF0_00_82, 1'b0);            // s set on a byte operation
    send_instr(4, 48'h7F_FE_46_83, 1'b0);
    send_instr(2, 48'h80_04, 1'b0);
    send_instr(3, 48'h7F_FF_05, 1'b1);            // last on the completing byte
  endtask

  // Program ends inside an instruction at each stage.
  task automatic test_truncation();
    send_instr(1, 48'hB8, 1'b1);
    send_instr(2, 48'hC0_81, 1'b1);
    send_instr(3, 48'h34_06_8B, 1'b1);
    send_instr(3, 48'hFE_86_81, 1'b1);
    send_instr(5, 48'h34_01_00_06_C7, 1'b1);
  endtask

  // Well-formed instructions with random content, some cut short, mixed with noise bytes.
  task automatic test_random_stream(input int byte_target);
    logic [7:0]  op;
    logic [7:0]  modrm;
    logic [47:0] bytes;
    logic [3:0]  f;
    int          n;
    while (bytes_sent < byte_target) begin
      if ($urandom_range(0, 11) == 0) begin
        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        case ($urandom_range(0, 7))
          0:       op = 8'h88 + 8'($urandom_range(0, 3));
          1:       op = 8'hC6 + 8'($urandom_range(0, 1));
          2:       op = 8'hB0 + 8'($urandom_range(0, 15));
          3:       op = 8'hA0 + 8'($urandom_range(0, 1));
          4:       op = 8'hA2 + 8'($urandom_range(0, 1));
          5:       op = 8'h00 + 8'($urandom_range(0, 3));
          6:       op = 8'h80 + 8'($urandom_range(0, 3));
          default: op = 8'h04 + 8'($urandom_range(0, 1));
        endcase
        modrm = 8'($urandom);
        if ($urandom_range(0, 5) == 0) modrm = {2'b00, modrm[5:3], 3'd6};
        f = opcode_form(op);
        bytes = {16'($urandom), 32'($urandom)};
        bytes[7:0] = op;
        if (uses_modrm(f)) bytes[15:8] = modrm;
        n = 1 + (uses_modrm(f) ? 1 : 0) + addr_bytes(f, modrm) + data_bytes(f, op);
        case ($urandom_range(0, 19))
          0, 1:    send_instr($urandom_range(1, n - 1), bytes, 1'b1);
          2:       send_instr(n, bytes, 1'b1);
          default: send_instr(n, bytes, 1'b0);
        endcase
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_each_form();
    test_truncation();
    drain_decodes();
    test_random_stream(1200);
    drain_decodes();
    calm_phase = 1'b1;
    test_random_stream(1450);
    // Let the last results come out, then look for stray ones.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_decodes.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mad_pkg.sv
hw/rtl/mov_add_instruction_decoder_top.sv
tb/mov_add_instruction_decoder_top_test.sv
